[rtl/trd_pkg.sv]
package trd_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 2;
	localparam logic [2:0] PIXEL_BYTES_RST = 3'd3;
	localparam logic [2:0] PIXEL_BYTES_MIN = 3'd1;
	localparam logic [2:0] PIXEL_BYTES_MAX = 3'd4;
	localparam logic [31:0] IMAGE_PIXELS_RST = 32'd0;
	localparam logic [7:0] RUN_FLAG = 8'h80;
	localparam logic [7:0] COUNT_MASK = 8'h7f;

	typedef enum logic {
		REG_PIXEL_BYTES = 1'b0,
		REG_IMAGE_PIXELS = 1'b1
	} reg_index_t;

	typedef enum logic [4:0] {
		PH_HEADER = 5'b00001,
		PH_REPEAT = 5'b00010,
		PH_RAW = 5'b00100,
		PH_DONE = 5'b01000,
		PH_ERROR = 5'b10000
	} phase_t;

	typedef enum logic [1:0] {
		ST_BUSY = 2'd0,
		ST_DONE = 2'd1,
		ST_ERROR = 2'd2
	} status_t;

	// One decoded byte: a pixel repeated count times, and the status it ends with.
	typedef struct packed {
		logic [31:0] pixel;
		logic [7:0] count;
		status_t status;
	} cmd_t;

endpackage

[rtl/trd_front.sv]
module trd_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] data_byte,
	input logic first_byte,
	input logic final_byte,
	input logic [2:0] pixel_bytes,
	input logic [31:0] image_pixels,
	input logic queue_full,
	output logic push,
	output trd_pkg::cmd_t push_cmd
);
	import trd_pkg::*;

	phase_t phase_q;
	logic [7:0] pkt_left_q;
	logic [1:0] byte_idx_q;
	logic [31:0] assembly_q;
	logic [31:0] img_left_q;

	phase_t eff_phase;
	logic [7:0] eff_pkt;
	logic [1:0] eff_idx;
	logic [31:0] eff_asm;
	logic [31:0] eff_img;

	phase_t nxt_phase;
	logic [7:0] nxt_pkt;
	logic [1:0] nxt_idx;
	logic [31:0] nxt_asm;
	logic [31:0] nxt_img;

	logic [2:0] pb_clamped;
	logic [7:0] hdr_cnt;
	logic [31:0] asm_new;
	logic byte_last;
	logic [31:0] raw_dec;
	logic [7:0] pkt_dec;
	logic [32:0] rep_diff;
	logic active;
	logic accept;

	assign in_ready = !queue_full;
	assign accept = in_valid && in_ready;

	always_comb begin
		if (pixel_bytes < PIXEL_BYTES_MIN) begin
			pb_clamped = PIXEL_BYTES_MIN;
		end else if (pixel_bytes > PIXEL_BYTES_MAX) begin
			pb_clamped = PIXEL_BYTES_MAX;
		end else begin
			pb_clamped = pixel_bytes;
		end
	end

	// A first byte clears the decode state before the byte itself is decoded.
	assign eff_phase = first_byte ? PH_HEADER : phase_q;
	assign eff_pkt = first_byte ? 8'd0 : pkt_left_q;
	assign eff_idx = first_byte ? 2'd0 : byte_idx_q;
	assign eff_asm = first_byte ? 32'd0 : assembly_q;
	assign eff_img = first_byte ? image_pixels : img_left_q;

	assign active = (eff_phase == PH_HEADER) || (eff_phase == PH_REPEAT)
		|| (eff_phase == PH_RAW);
	assign hdr_cnt = (data_byte & COUNT_MASK) + 8'd1;
	assign asm_new = eff_asm | ({24'd0, data_byte} << {eff_idx, 3'b000});
	assign byte_last = ({1'b0, eff_idx} + 3'd1) >= pb_clamped;
	assign raw_dec = eff_img - 32'd1;
	assign pkt_dec = eff_pkt - 8'd1;
	assign rep_diff = {1'b0, eff_img} - {25'd0, eff_pkt};

	always_comb begin
		nxt_phase = eff_phase;
		nxt_pkt = eff_pkt;
		nxt_idx = eff_idx;
		nxt_asm = eff_asm;
		nxt_img = eff_img;
		push_cmd.pixel = 32'd0;
		push_cmd.count = 8'd0;
		push_cmd.status = ST_BUSY;
		unique case (eff_phase)
			PH_HEADER: begin
				if (eff_img == 32'd0) begin
					nxt_phase = PH_DONE;
				end else begin
					nxt_idx = 2'd0;
					nxt_asm = 32'd0;
					nxt_pkt = hdr_cnt;
					if ((data_byte & RUN_FLAG) != 8'd0) begin
						nxt_phase = PH_REPEAT;
					end else if ({24'd0, hdr_cnt} > eff_img) begin
						nxt_phase = PH_ERROR;
					end else begin
						nxt_phase = PH_RAW;
					end
				end
			end
			PH_RAW: begin
				if (!byte_last) begin
					nxt_asm = asm_new;
					nxt_idx = eff_idx + 2'd1;
				end else begin
					nxt_idx = 2'd0;
					nxt_asm = 32'd0;
					push_cmd.pixel = asm_new;
					push_cmd.count = 8'd1;
					nxt_img = raw_dec;
					nxt_pkt = pkt_dec;
					if (raw_dec == 32'd0) begin
						nxt_phase = PH_DONE;
					end else if (pkt_dec == 8'd0) begin
						nxt_phase = PH_HEADER;
					end
				end
			end
			PH_REPEAT: begin
				if (!byte_last) begin
					nxt_asm = asm_new;
					nxt_idx = eff_idx + 2'd1;
				end else begin
					nxt_idx = 2'd0;
					nxt_asm = 32'd0;
					nxt_pkt = 8'd0;
					push_cmd.pixel = asm_new;
					// A borrow means the run is longer than what the image still needs.
					if (rep_diff[32]) begin
						push_cmd.count = eff_img[7:0];
						nxt_img = 32'd0;
						nxt_phase = PH_ERROR;
					end else begin
						push_cmd.count = eff_pkt;
						nxt_img = rep_diff[31:0];
						nxt_phase = (rep_diff[31:0] == 32'd0) ? PH_DONE : PH_HEADER;
					end
				end
			end
			default: begin
			end
		endcase
		if (active && final_byte && nxt_phase != PH_DONE && nxt_phase != PH_ERROR) begin
			nxt_phase = PH_ERROR;
		end
		if (active && nxt_phase == PH_DONE) begin
			push_cmd.status = ST_DONE;
		end else if (active && nxt_phase == PH_ERROR) begin
			push_cmd.status = ST_ERROR;
		end
	end

	assign push = accept && active && (push_cmd.count != 8'd0 || push_cmd.status != ST_BUSY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pkt_left_q <= 8'd0;
			byte_idx_q <= 2'd0;
			assembly_q <= 32'd0;
			img_left_q <= 32'd0;
		end else if (accept) begin
			phase_q <= nxt_phase;
			pkt_left_q <= nxt_pkt;
			byte_idx_q <= nxt_idx;
			assembly_q <= nxt_asm;
			img_left_q <= nxt_img;
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> push_cmd.count <= 8'd128)
		else $error("Front pushed a run longer than one packet.");
`endif

endmodule

[rtl/trd_queue.sv]
module trd_queue #(
	parameter int unsigned DEPTH = trd_pkg::QUEUE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input trd_pkg::cmd_t push_cmd,
	input logic pop,
	output trd_pkg::cmd_t head,
	output logic full,
	output logic empty
);
	import trd_pkg::*;

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	cmd_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = count_q == CNT_W'(DEPTH);
	assign empty = count_q == '0;
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("Queue written while full.");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("Queue read while empty.");
`endif

endmodule

[rtl/trd_back.sv]
module trd_back (
	input logic clk,
	input logic arst_n,
	input trd_pkg::cmd_t head,
	input logic empty,
	output logic pop,
	output logic out_valid,
	input logic out_ready,
	output logic [31:0] pixel_lo,
	output logic [31:0] pixel_hi,
	output logic [1:0] pixel_count,
	output logic run_end,
	output logic [1:0] status
);
	import trd_pkg::*;

	logic [7:0] sent_q;
	logic out_valid_q;
	logic [31:0] pixel_lo_q;
	logic [31:0] pixel_hi_q;
	logic [1:0] pixel_count_q;
	logic run_end_q;
	status_t status_q;

	logic [7:0] left;
	logic two;
	logic last;
	logic load;

	assign left = head.count - sent_q;
	assign two = left >= 8'd2;
	assign last = left <= 8'd2;
	assign load = !empty && (!out_valid_q || out_ready);
	assign pop = load && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sent_q <= 8'd0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				sent_q <= last ? 8'd0 : sent_q + 8'd2;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pixel_lo_q <= (left != 8'd0) ? head.pixel : 32'd0;
			pixel_hi_q <= two ? head.pixel : 32'd0;
			pixel_count_q <= two ? 2'd2 : left[1:0];
			run_end_q <= last;
			status_q <= last ? head.status : ST_BUSY;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_lo = pixel_lo_q;
	assign pixel_hi = pixel_hi_q;
	assign pixel_count = pixel_count_q;
	assign run_end = run_end_q;
	assign status = status_q;

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pixel_count == 2'd0 |-> run_end && status != ST_BUSY)
		else $error("Empty word without a status.");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_BUSY |-> run_end)
		else $error("Status reported before the last word of a byte.");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pixel_count != 2'd3)
		else $error("Word carries more than two pixels.");
`endif

endmodule

[rtl/tga_rle_pixel_decoder_unit.sv]
// A byte's first word is written into the command queue and then registered in the
// output register before it is valid.
// Throughput: one byte per cycle; a repeat run of N pixels leaves the output as
// ceil(N/2) words, and input stalls once the command queue between the parser and
// the output stage is full.
// Reset (arst_n low) clears the decode state, the queue and the output valid, and sets
// pixel_bytes to 3 and image_pixels to 0.
module tga_rle_pixel_decoder_unit #(
	parameter int unsigned QUEUE_DEPTH = trd_pkg::QUEUE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] data_byte,
	input logic first_byte,
	input logic final_byte,
	output logic out_valid,
	input logic out_ready,
	output logic [31:0] pixel_lo,
	output logic [31:0] pixel_hi,
	output logic [1:0] pixel_count,
	output logic run_end,
	output logic [1:0] status,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_index,
	input logic [31:0] cfg_data
);
	import trd_pkg::*;

	logic [2:0] pixel_bytes_q;
	logic [31:0] image_pixels_q;

	logic push;
	logic pop;
	logic queue_full;
	logic queue_empty;
	cmd_t push_cmd;
	cmd_t head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_bytes_q <= PIXEL_BYTES_RST;
			image_pixels_q <= IMAGE_PIXELS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_index_t'(cfg_index))
				REG_PIXEL_BYTES: pixel_bytes_q <= cfg_data[2:0];
				REG_IMAGE_PIXELS: image_pixels_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	trd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.first_byte(first_byte),
		.final_byte(final_byte),
		.pixel_bytes(pixel_bytes_q),
		.image_pixels(image_pixels_q),
		.queue_full(queue_full),
		.push(push),
		.push_cmd(push_cmd)
	);

	trd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_cmd(push_cmd),
		.pop(pop),
		.head(head),
		.full(queue_full),
		.empty(queue_empty)
	);

	trd_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.empty(queue_empty),
		.pop(pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pixel_lo(pixel_lo),
		.pixel_hi(pixel_hi),
		.pixel_count(pixel_count),
		.run_end(run_end),
		.status(status)
	);

endmodule

[bench/tb_tga_rle_pixel_decoder_unit.sv]
`timescale 1ns / 1ps

module tb_tga_rle_pixel_decoder_unit;
	import trd_pkg::*;

	localparam int unsigned QUIET_LIMIT = 5000;

	typedef struct {
		logic [31:0] lo;
		logic [31:0] hi;
		logic [1:0] count;
		logic run_end;
		status_t st;
	} pixel_word_t;

	class tga_rle_scoreboard;
		logic [2:0] pixel_bytes;
		logic [31:0] image_pixels;
		phase_t phase;
		logic [7:0] packet_left;
		logic [1:0] byte_idx;
		logic [31:0] assembly;
		logic [31:0] image_left;
		pixel_word_t pending[$];
		int unsigned mismatches;
		int unsigned words_checked;

		function new();
			pixel_bytes = PIXEL_BYTES_RST;
			image_pixels = IMAGE_PIXELS_RST;
			mismatches = 0;
			words_checked = 0;
			restart_image();
		endfunction

		function void restart_image();
			phase = PH_HEADER;
			packet_left = '0;
			byte_idx = '0;
			assembly = '0;
			image_left = '0;
		endfunction

		function void set_reg(reg_index_t idx, logic [31:0] val);
			if (idx == REG_PIXEL_BYTES) begin
				pixel_bytes = val[2:0];
			end else begin
				image_pixels = val;
			end
		endfunction

		function pixel_word_t pix_word(logic [31:0] lo, logic [31:0] hi, logic [1:0] n);
			pixel_word_t w;
			w.lo = lo;
			w.hi = hi;
			w.count = n;
			w.run_end = 1'b0;
			w.st = ST_BUSY;
			return w;
		endfunction

		// Returns 1 when the byte reached the decoder, 0 when it was ignored.
		function bit note_byte(logic [7:0] b, logic first, logic fin);
			pixel_word_t fresh[$];
			int unsigned pb;
			int unsigned want;
			int unsigned fit;
			int unsigned k;
			logic [31:0] px;
			if (first) begin
				restart_image();
				image_left = image_pixels;
			end
			if (phase == PH_DONE || phase == PH_ERROR)
				return 0;
			pb = (pixel_bytes < 1) ? 1 : (pixel_bytes > 4) ? 4 : int'(pixel_bytes);
			if (phase == PH_HEADER && image_left == 0) begin
				phase = PH_DONE;
			end else if (phase == PH_HEADER) begin
				packet_left = {1'b0, b[6:0] & COUNT_MASK[6:0]} + 8'd1;
				byte_idx = '0;
				assembly = '0;
				if ((b & RUN_FLAG) != 0) begin
					phase = PH_REPEAT;
				end else if (32'(packet_left) > image_left) begin
					phase = PH_ERROR;
				end else begin
					phase = PH_RAW;
				end
			end else begin
				assembly = assembly | (32'(b) << (8 * int'(byte_idx)));
				if (int'(byte_idx) + 1 < pb) begin
					byte_idx = byte_idx + 2'd1;
				end else begin
					px = assembly;
					byte_idx = '0;
					assembly = '0;
					if (phase == PH_RAW) begin
						fresh.push_back(pix_word(px, 32'd0, 2'd1));
						image_left = image_left - 32'd1;
						packet_left = packet_left - 8'd1;
						if (image_left == 0) begin
							phase = PH_DONE;
						end else if (packet_left == 0) begin
							phase = PH_HEADER;
						end
					end else begin
						want = packet_left;
						fit = (want < image_left) ? want : image_left;
						for (k = 0; k + 1 < fit; k += 2)
							fresh.push_back(pix_word(px, px, 2'd2));
						if (k < fit)
							fresh.push_back(pix_word(px, 32'd0, 2'd1));
						image_left = image_left - fit;
						packet_left = '0;
						if (want > fit) begin
							phase = PH_ERROR;
						end else if (image_left == 0) begin
							phase = PH_DONE;
						end else begin
							phase = PH_HEADER;
						end
					end
				end
			end
			if (fin && phase != PH_DONE && phase != PH_ERROR)
				phase = PH_ERROR;
			if (phase == PH_DONE || phase == PH_ERROR) begin
				if (fresh.size() == 0)
					fresh.push_back(pix_word(32'd0, 32'd0, 2'd0));
				fresh[fresh.size() - 1].st = (phase == PH_DONE) ? ST_DONE : ST_ERROR;
			end
			if (fresh.size() > 0)
				fresh[fresh.size() - 1].run_end = 1'b1;
			foreach (fresh[i])
				pending.push_back(fresh[i]);
			return 1;
		endfunction

		task report_mismatch(string what, logic [31:0] got, logic [31:0] wanted);
			mismatches++;
			if (mismatches <= 50)
				$display("%0t mismatch on %s: got %h, wanted %h", $realtime, what, got, wanted);
		endtask

		task check_word(logic [31:0] lo, logic [31:0] hi, logic [1:0] n, logic re,
				logic [1:0] st);
			pixel_word_t w;
			if (pending.size() == 0) begin
				report_mismatch("word with nothing pending", lo, 32'd0);
				return;
			end
			w = pending.pop_front();
			words_checked++;
			if (lo !== w.lo) report_mismatch("pixel_lo", lo, w.lo);
			if (hi !== w.hi) report_mismatch("pixel_hi", hi, w.hi);
			if (n !== w.count) report_mismatch("pixel_count", 32'(n), 32'(w.count));
			if (re !== w.run_end) report_mismatch("run_end", 32'(re), 32'(w.run_end));
			if (st !== w.st) report_mismatch("status", 32'(st), 32'(w.st));
		endtask
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic [7:0] data_byte = '0;
	logic first_byte = 1'b0;
	logic final_byte = 1'b0;
	logic out_ready = 1'b0;
	logic cfg_valid = 1'b0;
	reg_index_t cfg_index = REG_PIXEL_BYTES;
	logic [31:0] cfg_data = '0;
	logic in_ready;
	logic out_valid;
	logic [31:0] pixel_lo;
	logic [31:0] pixel_hi;
	logic [1:0] pixel_count;
	logic run_end;
	logic [1:0] status;
	logic cfg_ready;

	tga_rle_scoreboard sb = new();
	int unsigned idle_pct = 35;
	int unsigned cur_pb = 3;
	int unsigned decoded_bytes = 0;
	int unsigned quiet = 0;

	tga_rle_pixel_decoder_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.first_byte(first_byte),
		.final_byte(final_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pixel_lo(pixel_lo),
		.pixel_hi(pixel_hi),
		.pixel_count(pixel_count),
		.run_end(run_end),
		.status(status),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_word(pixel_lo, pixel_hi, pixel_count, run_end, status);
		out_ready <= ($urandom_range(0, 99) >= idle_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
		end
		if (quiet >= QUIET_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic first, input logic fin);
		if ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		first_byte <= first;
		final_byte <= fin;
		do @(posedge clk); while (!in_ready);
		if (sb.note_byte(b, first, fin))
			decoded_bytes++;
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
	endtask

	task automatic configure(input logic [2:0] pb, input logic [31:0] npix);
		write_reg(REG_PIXEL_BYTES, {29'd0, pb});
		write_reg(REG_IMAGE_PIXELS, npix);
		cfg_valid <= 1'b0;
		cur_pb = pb;
	endtask

	// The decoder may still hold silent bytes after the last word, so keep clocking once nothing is pending.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic send_image(input int unsigned npix);
		int unsigned px_left;
		int unsigned cnt;
		int unsigned lim;
		int unsigned pkts;
		int unsigned r;
		int unsigned nbytes;
		int unsigned j;
		bit first;
		bit rep;
		bit ended;
		bit fin;
		px_left = npix;
		first = 1'b1;
		ended = 1'b0;
		pkts = 0;
		if (npix == 0) begin
			send_byte(8'($urandom_range(0, 255)), 1'b1, 1'($urandom_range(0, 1)));
			return;
		end
		while (px_left > 0 && !ended) begin
			r = $urandom_range(0, 99);
			if (r < 4 || pkts == 6) begin
				send_byte(8'($urandom_range(0, 255)), first, 1'b1);
				ended = 1'b1;
			end else begin
				rep = 1'($urandom_range(0, 1));
				lim = (px_left < 16) ? px_left : 16;
				if (rep) begin
					cnt = (r < 12) ? $urandom_range(1, 128) : $urandom_range(1, lim);
				end else if (r < 12 && px_left < 128) begin
					cnt = $urandom_range(px_left + 1, 128);
				end else begin
					cnt = $urandom_range(1, (lim < 5) ? lim : 5);
				end
				send_byte({rep, 7'(cnt - 1)}, first, 1'b0);
				first = 1'b0;
				pkts++;
				if (!rep && cnt > px_left) begin
					ended = 1'b1;
				end else begin
					nbytes = (rep ? 1 : cnt) * cur_pb;
					for (j = 0; j < nbytes && !ended; j++) begin
						fin = ($urandom_range(0, 59) == 0) ||
							(j == nbytes - 1 && cnt >= px_left && $urandom_range(0, 1) == 1);
						send_byte(8'($urandom_range(0, 255)), 1'b0, fin);
						ended = fin;
					end
					if (!ended) begin
						if (rep && cnt > px_left)
							ended = 1'b1;
						px_left = px_left - ((cnt < px_left) ? cnt : px_left);
					end
				end
			end
		end
		repeat ($urandom_range(0, 2))
			send_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
	endtask

	initial begin
		int unsigned setting;
		int unsigned npix;
		int unsigned directed;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With no image started, the first header finds the image already full.
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(8'h55, 1'b0, 1'b1);
		send_byte(8'hff, 1'b1, 1'b0);
		settle();

		configure(3'd1, 32'd6);
		send_byte(8'h81, 1'b1, 1'b0);
		send_byte(8'hff, 1'b0, 1'b0);
		send_byte(8'h01, 1'b0, 1'b0);
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(8'ha5, 1'b0, 1'b0);
		send_byte(8'hff, 1'b0, 1'b0);
		send_byte(8'h3c, 1'b0, 1'b0);
		settle();

		// A full 128-pixel run, then a raw packet larger than what is left.
		configure(3'd4, 32'd130);
		send_byte(8'hff, 1'b1, 1'b0);
		send_byte(8'h01, 1'b0, 1'b0);
		send_byte(8'h80, 1'b0, 1'b0);
		send_byte(8'hff, 1'b0, 1'b0);
		send_byte(8'h7e, 1'b0, 1'b0);
		send_byte(8'h02, 1'b0, 1'b0);
		send_byte(8'h7f, 1'b1, 1'b0);
		send_byte(8'h12, 1'b0, 1'b1);
		settle();

		configure(3'd2, 32'd3);
		send_byte(8'h80, 1'b1, 1'b0);
		send_byte(8'h34, 1'b0, 1'b0);
		send_byte(8'h12, 1'b0, 1'b0);
		send_byte(8'h81, 1'b0, 1'b0);
		send_byte(8'hc3, 1'b0, 1'b0);
		send_byte(8'h5a, 1'b0, 1'b1);

		directed = decoded_bytes;
		setting = 0;
		while (decoded_bytes < directed + 100) begin
			settle();
			npix = (setting == 1) ? 32'hffff_ffff : (setting == 2) ? 0 : $urandom_range(1, 40);
			configure(3'(setting % 4 + 1), npix);
			idle_pct = (setting == 0) ? 0 : 35;
			repeat ($urandom_range(1, 3)) send_image(npix);
			setting++;
		end
		settle();

		$display("Decoded %0d bytes over %0d register settings; %0d output words checked.",
			decoded_bytes, setting + 4, sb.words_checked);
		$display("Mismatches found: %0d.", sb.mismatches);
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
